FILE: sv/rrm_pkg.sv
package rrm_pkg;

    localparam int IN_W         = 16;
    localparam int QW           = 34;
    localparam int CORDIC_STEPS = 30;

    localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032874;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef logic signed [QW-1:0] q30_t;

    typedef struct packed {
        q30_t c;
        q30_t s;
    } cs_t;

    // product of two q30 values, floor shift by 30
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return p[QW+29:30];
    endfunction

    // quadrant fold of the cordic result
    function automatic cs_t quad_map(input logic [1:0] quad, input q30_t x, input q30_t y);
        cs_t r;
        case (quad)
            2'd0:    begin r.c = x;  r.s = y;  end
            2'd1:    begin r.c = -y; r.s = x;  end
            2'd2:    begin r.c = -x; r.s = -y; end
            default: begin r.c = y;  r.s = -x; end
        endcase
        return r;
    endfunction

endpackage

FILE: sv/random_rotation_matrix_unit.sv
// channel | signals                   | payload
// s_axis  | s_tvalid s_tready s_tdata | 48 bits: angle_frac_a, angle_frac_b, height_frac
// m_axis  | m_tvalid m_tready m_tdata | m11..m33, FRAC_BITS+2 bits each, zero padded
//
// 37 register stages from input transfer to output; one triple per cycle while the output is not stalled.
// the depth is set by the 30-step cordic, one iteration a stage, with the
// integer square root retiring one root bit per stage beside it.
// rst_n clears only the valid bits; payload registers are not reset.
// a stall at the output holds every stage, s_tready drops only while the
// output register is full and not taken.
module random_rotation_matrix_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // angle_frac_a [15:0], angle_frac_b [31:16], height_frac [47:32]
    input  logic [3*rrm_pkg::IN_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33 from bit 0 up, then zero fill
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

    localparam int OW    = FRAC_BITS + 2;
    localparam int OUT_W = ((9*OW+7)/8)*8;
    localparam int NS    = rrm_pkg::CORDIC_STEPS;
    localparam int NST   = NS + 7;

    logic           en;
    logic [NST-1:0] vld_reg;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage 0: turns, quadrant fold to [-1/8,1/8), height in q30
    logic [31:0] fa_m, fb_m, fh_m, ta, tb;
    logic [31:0] in_mask;

    assign in_mask = (32'd1 << FRAC_BITS) - 32'd1;
    assign fa_m = {16'd0, s_tdata[15:0]}  & in_mask;
    assign fb_m = {16'd0, s_tdata[31:16]} & in_mask;
    assign fh_m = {16'd0, s_tdata[47:32]} & in_mask;
    assign ta   = fa_m << (32 - FRAC_BITS);
    assign tb   = fb_m << (32 - FRAC_BITS);

    logic signed [29:0] ra_reg, rb_reg;
    logic [1:0]         qa0_reg, qb0_reg;
    logic [29:0]        h0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg  <= $signed(ta[29:0]);
            rb_reg  <= $signed(tb[29:0]);
            qa0_reg <= ta[31:30] + {1'b0, ta[29]};
            qb0_reg <= tb[31:30] + {1'b0, tb[29]};
            h0_reg  <= fh_m[29:0] << (30 - FRAC_BITS);
        end
    end

    // stage 1: radians and the square root operand
    logic signed [61:0] za_p, zb_p;
    logic [60:0]        hp;

    assign za_p = ra_reg * $signed({1'b0, rrm_pkg::HALF_PI_Q30});
    assign zb_p = rb_reg * $signed({1'b0, rrm_pkg::HALF_PI_Q30});
    assign hp   = {31'd0, h0_reg} * ({31'd0, 30'd0} + (61'd1 << 30) - {31'd0, h0_reg});

    rrm_pkg::q30_t xa_reg [0:NS], ya_reg [0:NS], za_reg [0:NS];
    rrm_pkg::q30_t xb_reg [0:NS], yb_reg [0:NS], zb_reg [0:NS];
    logic [1:0]    qa_reg [0:NS], qb_reg [0:NS];
    logic [29:0]   h_reg  [0:NS];
    logic [59:0]   rad_reg [0:NS];
    logic [32:0]   rem_reg [0:NS];
    logic [29:0]   root_reg [0:NS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg[0]   <= rrm_pkg::q30_t'(rrm_pkg::CORDIC_GAIN_Q30);
            ya_reg[0]   <= '0;
            za_reg[0]   <= rrm_pkg::q30_t'(za_p >>> 30);
            xb_reg[0]   <= rrm_pkg::q30_t'(rrm_pkg::CORDIC_GAIN_Q30);
            yb_reg[0]   <= '0;
            zb_reg[0]   <= rrm_pkg::q30_t'(zb_p >>> 30);
            qa_reg[0]   <= qa0_reg;
            qb_reg[0]   <= qb0_reg;
            h_reg[0]    <= h0_reg;
            rad_reg[0]  <= hp[59:0];
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // cordic iteration and one root bit per stage
    for (genvar i = 0; i < NS; i++)
    begin : g_step
        rrm_pkg::q30_t atan_v;
        logic [32:0]   rem2, trial;

        assign atan_v = rrm_pkg::q30_t'({2'b00, rrm_pkg::ATAN_Q30[i]});
        assign rem2   = {rem_reg[i][30:0], rad_reg[i][59:58]};
        assign trial  = {1'b0, root_reg[i], 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!za_reg[i][rrm_pkg::QW-1])
                begin
                    xa_reg[i+1] <= xa_reg[i] - (ya_reg[i] >>> i);
                    ya_reg[i+1] <= ya_reg[i] + (xa_reg[i] >>> i);
                    za_reg[i+1] <= za_reg[i] - atan_v;
                end
                else
                begin
                    xa_reg[i+1] <= xa_reg[i] + (ya_reg[i] >>> i);
                    ya_reg[i+1] <= ya_reg[i] - (xa_reg[i] >>> i);
                    za_reg[i+1] <= za_reg[i] + atan_v;
                end
                if (!zb_reg[i][rrm_pkg::QW-1])
                begin
                    xb_reg[i+1] <= xb_reg[i] - (yb_reg[i] >>> i);
                    yb_reg[i+1] <= yb_reg[i] + (xb_reg[i] >>> i);
                    zb_reg[i+1] <= zb_reg[i] - atan_v;
                end
                else
                begin
                    xb_reg[i+1] <= xb_reg[i] + (yb_reg[i] >>> i);
                    yb_reg[i+1] <= yb_reg[i] - (xb_reg[i] >>> i);
                    zb_reg[i+1] <= zb_reg[i] + atan_v;
                end
                if (rem2 >= trial)
                begin
                    rem_reg[i+1]  <= rem2 - trial;
                    root_reg[i+1] <= {root_reg[i][28:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1]  <= rem2;
                    root_reg[i+1] <= {root_reg[i][28:0], 1'b0};
                end
                rad_reg[i+1] <= {rad_reg[i][57:0], 2'b00};
                qa_reg[i+1]  <= qa_reg[i];
                qb_reg[i+1]  <= qb_reg[i];
                h_reg[i+1]   <= h_reg[i];
            end
        end
    end

    // quadrant map, 2*sqrt(h*(1-h)), 2h and 1-2h
    rrm_pkg::cs_t  cs_a, cs_b;
    rrm_pkg::q30_t ca_reg, sa_reg, cb_reg, sb_reg, sq3_reg, h2_reg, m33q_reg;

    assign cs_a = rrm_pkg::quad_map(qa_reg[NS], xa_reg[NS], ya_reg[NS]);
    assign cs_b = rrm_pkg::quad_map(qb_reg[NS], xb_reg[NS], yb_reg[NS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg   <= cs_a.c;
            sa_reg   <= cs_a.s;
            cb_reg   <= cs_b.c;
            sb_reg   <= cs_b.s;
            sq3_reg  <= rrm_pkg::q30_t'({root_reg[NS], 1'b0});
            h2_reg   <= rrm_pkg::q30_t'({h_reg[NS], 1'b0});
            m33q_reg <= rrm_pkg::q30_t'(34'sd1 << 30) - rrm_pkg::q30_t'({h_reg[NS], 1'b0});
        end
    end

    // 2h*sin, 2h*cos and the axis terms
    rrm_pkg::q30_t t1_reg, t2_reg, pc_reg, ps_reg;
    rrm_pkg::q30_t ca1_reg, sa1_reg, cb1_reg, sb1_reg, m33q1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= rrm_pkg::qmul(h2_reg, sb_reg);
            t2_reg    <= rrm_pkg::qmul(h2_reg, cb_reg);
            pc_reg    <= rrm_pkg::qmul(sq3_reg, cb_reg);
            ps_reg    <= rrm_pkg::qmul(sq3_reg, sb_reg);
            ca1_reg   <= ca_reg;
            sa1_reg   <= sa_reg;
            cb1_reg   <= cb_reg;
            sb1_reg   <= sb_reg;
            m33q1_reg <= m33q_reg;
        end
    end

    rrm_pkg::q30_t s2_reg, c2_reg, sc_reg, pc2_reg, ps2_reg;
    rrm_pkg::q30_t ca2_reg, sa2_reg, m33q2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg    <= rrm_pkg::qmul(t1_reg, sb1_reg) - rrm_pkg::q30_t'(34'sd1 << 30);
            c2_reg    <= rrm_pkg::qmul(t2_reg, cb1_reg) - rrm_pkg::q30_t'(34'sd1 << 30);
            sc_reg    <= rrm_pkg::qmul(t1_reg, cb1_reg);
            pc2_reg   <= pc_reg;
            ps2_reg   <= ps_reg;
            ca2_reg   <= ca1_reg;
            sa2_reg   <= sa1_reg;
            m33q2_reg <= m33q1_reg;
        end
    end

    // rotation by angle a
    rrm_pkg::q30_t p_cc2, p_ssc, p_sc2, p_csc, p_ss2, p_cs2, p_cpc, p_sps, p_spc, p_cps;
    rrm_pkg::q30_t pc3_reg, ps3_reg, m33q3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_cc2     <= rrm_pkg::qmul(ca2_reg, c2_reg);
            p_ssc     <= rrm_pkg::qmul(sa2_reg, sc_reg);
            p_sc2     <= rrm_pkg::qmul(sa2_reg, c2_reg);
            p_csc     <= rrm_pkg::qmul(ca2_reg, sc_reg);
            p_ss2     <= rrm_pkg::qmul(sa2_reg, s2_reg);
            p_cs2     <= rrm_pkg::qmul(ca2_reg, s2_reg);
            p_cpc     <= rrm_pkg::qmul(ca2_reg, pc2_reg);
            p_sps     <= rrm_pkg::qmul(sa2_reg, ps2_reg);
            p_spc     <= rrm_pkg::qmul(sa2_reg, pc2_reg);
            p_cps     <= rrm_pkg::qmul(ca2_reg, ps2_reg);
            pc3_reg   <= pc2_reg;
            ps3_reg   <= ps2_reg;
            m33q3_reg <= m33q2_reg;
        end
    end

    // round half up to the output lsb, clamp to +-1
    function automatic logic [OW-1:0] to_out(input logic signed [rrm_pkg::QW:0] v);
        logic signed [rrm_pkg::QW:0] s, r;
        logic signed [rrm_pkg::QW:0] lim;
        lim = (rrm_pkg::QW+1)'(1) <<< FRAC_BITS;
        s   = v + ((rrm_pkg::QW+1)'(1) <<< (29 - FRAC_BITS));
        r   = s >>> (30 - FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[OW-1:0];
    endfunction

    function automatic logic signed [rrm_pkg::QW:0] sx(input rrm_pkg::q30_t v);
        return {v[rrm_pkg::QW-1], v};
    endfunction

    logic [9*OW-1:0]  mat;
    logic [OUT_W-1:0] out_reg;

    assign mat = {
        to_out(sx(p_spc) + sx(p_cps)),
        to_out(sx(p_cpc) - sx(p_sps)),
        to_out(sx(m33q3_reg)),
        to_out(sx(p_ssc) + sx(p_cs2)),
        to_out(sx(p_csc) - sx(p_ss2)),
        to_out(sx(ps3_reg)),
        to_out(sx(p_sc2) + sx(p_csc)),
        to_out(sx(p_cc2) - sx(p_ssc)),
        to_out(sx(pc3_reg))
    };

    // field order from bit 0: m11 m12 m13 m21 m22 m23 m31 m32 m33
    logic [9*OW-1:0] mat_ord;

    assign mat_ord = {
        mat[6*OW +: OW], mat[8*OW +: OW], mat[7*OW +: OW],
        mat[3*OW +: OW], mat[5*OW +: OW], mat[4*OW +: OW],
        mat[0 +: OW],    mat[2*OW +: OW], mat[1*OW +: OW]
    };

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= OUT_W'(mat_ord);
        end
    end

    assign m_tdata = out_reg;

endmodule

FILE: test/random_rotation_matrix_unit_tb.sv
module random_rotation_matrix_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int OW = FB + 2;
    localparam int DW = ((9*OW+7)/8)*8;
    localparam int N_RANDOM = 1130;
    localparam int LATENCY = 37;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint Q_ONE = 64'sd1 << 30;

    typedef logic [OW-1:0] entry_t;
    typedef struct {
        entry_t m [9];
    } matrix_t;
    typedef struct {
        logic [15:0] fa;
        logic [15:0] fb;
        logic [15:0] fh;
        logic        has_matrix;
        matrix_t     mat;
    } triple_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;

    random_rotation_matrix_unit #(.FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 clk = ~clk;

    matrix_t pending_matrices [$];
    int mismatch_count = 0;
    bit timed_out = 1'b0;
    bit no_idle = 1'b0;
    bit hold_sink = 1'b0;
    longint cycle_count = 0;

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return fshift(a * b, 30);
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic void turn_cos_sin(input logic [15:0] frac, output longint c,
                                         output longint s);
        logic [31:0] t;
        logic [1:0] quad;
        longint r, x, y, z, nx;
        t = {frac, 16'd0};
        quad = t[31:30];
        r = longint'(t[29:0]);
        if (r >= (64'sd1 << 29))
        begin
            r -= 64'sd1 << 30;
            quad = quad + 2'd1;
        end
        z = fshift(r * longint'(rrm_pkg::HALF_PI_Q30), 30);
        x = longint'(rrm_pkg::CORDIC_GAIN_Q30);
        y = 0;
        for (int i = 0; i < rrm_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                z -= longint'(rrm_pkg::ATAN_Q30[i]);
            end
            else
            begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                z += longint'(rrm_pkg::ATAN_Q30[i]);
            end
            x = nx;
        end
        case (quad)
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic entry_t round_entry(longint v);
        longint r;
        r = fshift(v + (64'sd1 << (29 - FB)), 30 - FB);
        if (r > (64'sd1 << FB)) r = 64'sd1 << FB;
        if (r < -(64'sd1 << FB)) r = -(64'sd1 << FB);
        return entry_t'(r);
    endfunction

    function automatic matrix_t rotation_of(logic [15:0] fa, logic [15:0] fb, logic [15:0] fh);
        matrix_t mt;
        longint ca, sa, cb, sb, h, sq3, s2, c2, sc, h2, pc, ps;
        turn_cos_sin(fa, ca, sa);
        turn_cos_sin(fb, cb, sb);
        h = longint'(fh) << (30 - FB);
        sq3 = 2 * root64(longint'(h) * longint'(Q_ONE - h));
        h2 = 2 * h;
        s2 = q30_mul(q30_mul(h2, sb), sb) - Q_ONE;
        c2 = q30_mul(q30_mul(h2, cb), cb) - Q_ONE;
        sc = q30_mul(q30_mul(h2, sb), cb);
        pc = q30_mul(sq3, cb);
        ps = q30_mul(sq3, sb);
        mt.m[0] = round_entry(q30_mul(ca, c2) - q30_mul(sa, sc));
        mt.m[1] = round_entry(q30_mul(sa, c2) + q30_mul(ca, sc));
        mt.m[2] = round_entry(pc);
        mt.m[3] = round_entry(q30_mul(ca, sc) - q30_mul(sa, s2));
        mt.m[4] = round_entry(q30_mul(sa, sc) + q30_mul(ca, s2));
        mt.m[5] = round_entry(ps);
        mt.m[6] = round_entry(q30_mul(ca, pc) - q30_mul(sa, ps));
        mt.m[7] = round_entry(q30_mul(sa, pc) + q30_mul(ca, ps));
        mt.m[8] = round_entry(Q_ONE - 2 * h);
        return mt;
    endfunction

    function automatic matrix_t identity_like(entry_t m13, entry_t m23, entry_t m33,
                                              entry_t d1, entry_t d2);
        matrix_t mt;
        foreach (mt.m[i]) mt.m[i] = '0;
        mt.m[0] = d1;
        mt.m[4] = d2;
        mt.m[2] = m13;
        mt.m[5] = m23;
        mt.m[8] = m33;
        return mt;
    endfunction

    // all zero: h=0 gives c2=s2=-1, so the matrix is diag(-1,-1,1)
    triple_row_t directed_rows [$];

    function automatic triple_row_t plain_row(logic [15:0] a, logic [15:0] b, logic [15:0] h);
        triple_row_t r;
        r.fa = a; r.fb = b; r.fh = h; r.has_matrix = 1'b0;
        return r;
    endfunction

    task automatic build_rows();
        triple_row_t r;
        r = plain_row(16'h0000, 16'h0000, 16'h0000);
        r.has_matrix = 1'b1;
        r.mat = identity_like('0, '0, entry_t'(18'sd65536), entry_t'(-18'sd65536),
                              entry_t'(-18'sd65536));
        directed_rows.push_back(r);
        directed_rows.push_back(plain_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(plain_row(16'h8000, 16'h8000, 16'h8000));
        directed_rows.push_back(plain_row(16'h4000, 16'hC000, 16'h4000));
        directed_rows.push_back(plain_row(16'hC000, 16'h4000, 16'hC000));
        // octant boundaries exercise the quadrant advance
        directed_rows.push_back(plain_row(16'h2000, 16'h1FFF, 16'h0001));
        directed_rows.push_back(plain_row(16'h6000, 16'hA000, 16'h7FFF));
        directed_rows.push_back(plain_row(16'hE000, 16'h5FFF, 16'h8001));
        directed_rows.push_back(plain_row(16'h0001, 16'hFFFE, 16'hFFFE));
        directed_rows.push_back(plain_row(16'h5555, 16'hAAAA, 16'h5555));
        directed_rows.push_back(plain_row(16'hAAAA, 16'h5555, 16'hAAAA));
        directed_rows.push_back(plain_row(16'h1000, 16'h3000, 16'hF000));
    endtask

    // pipeline depth sets the drain wait
    task automatic send_triple(logic [15:0] a, logic [15:0] b, logic [15:0] h,
                               bit has_fixed, matrix_t fixed_mat);
        matrix_t predicted;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        predicted = rotation_of(a, b, h);
        if (has_fixed && predicted != fixed_mat)
            $display("note: predictor differs from table row a=%h b=%h h=%h", a, b, h);
        s_tdata <= {h, b, a};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_matrices.push_back(has_fixed ? fixed_mat : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        matrix_t unused;
        logic [15:0] a, b, h;
        build_rows();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
            send_triple(directed_rows[i].fa, directed_rows[i].fb, directed_rows[i].fh,
                        directed_rows[i].has_matrix, directed_rows[i].mat);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
            begin
                // pause until the pipe drains
                s_tvalid <= 1'b0;
                while (pending_matrices.size() != 0) @(negedge clk);
            end
            if (n == 400) hold_sink = 1'b1;
            if (n == 900) no_idle = 1'b1;
            a = 16'($urandom); b = 16'($urandom); h = 16'($urandom);
            case ($urandom_range(0, 9))
                0: h = 16'($urandom_range(0, 3));
                1: h = 16'hFFFF - 16'($urandom_range(0, 3));
                2: a = {a[15:14], 14'h2000 ^ {13'd0, a[0]}};
                default: ;
            endcase
            send_triple(a, b, h, 1'b0, unused);
        end
        s_tvalid <= 1'b0;
        while (pending_matrices.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // sink side, with one long hold-off counted here
    initial
    begin
        int held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink && held < 200)
            begin
                m_tready <= 1'b0;
                held++;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        matrix_t want;
        entry_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matrices.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer %h", m_tdata);
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    got = m_tdata[i*OW +: OW];
                    if (got !== want.m[i])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("entry %0d mismatch: expected %h got %h", i,
                                     want.m[i], got);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end
endmodule

FILE: files.f
sv/rrm_pkg.sv
sv/random_rotation_matrix_unit.sv
test/random_rotation_matrix_unit_tb.sv
